// ----- rtl/core/fcc_pkg.sv -----
package fcc_pkg;

   parameter int NUM_FACES  = 4;
   parameter int COORD_W    = 16;
   parameter int NRM_W      = 12;
   parameter int OFF_W      = 28;
   parameter int PROD_W     = NRM_W + COORD_W;
   parameter int DIST_W     = PROD_W + 4;
   parameter int CSR_IDX_W  = 8;
   parameter int CSR_DATA_W = 64;
   parameter int OUT_CNT_W  = 21;
   parameter int QDEPTH     = 4;
   parameter int QPTR_W     = 2;
   parameter int QFILL_W    = 3;

   // register indexes
   parameter logic [CSR_IDX_W-1:0] CSR_FACE_ONE   = 8'd0;
   parameter logic [CSR_IDX_W-1:0] CSR_FACE_TWO   = 8'd1;
   parameter logic [CSR_IDX_W-1:0] CSR_FACE_THREE = 8'd2;
   parameter logic [CSR_IDX_W-1:0] CSR_FACE_FOUR  = 8'd3;

   typedef struct packed {
      logic signed [OFF_W-1:0] off;
      logic signed [NRM_W-1:0] nz;
      logic signed [NRM_W-1:0] ny;
      logic signed [NRM_W-1:0] nx;
   } plane_type;

   typedef struct packed {
      logic hit;
      logic last;
   } flags_type;

endpackage

// ----- rtl/core/fcc_if.sv -----
interface fcc_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] point_x;
   logic signed [15:0] point_y;
   logic signed [15:0] point_z;
   logic               point_invalid;
   logic               last_point;
   modport source(output valid, point_x, point_y, point_z, point_invalid, last_point,
                  input ready);
   modport sink(input valid, point_x, point_y, point_z, point_invalid, last_point,
                output ready);
endinterface

interface fcc_rsp_if;
   logic               valid;
   logic               ready;
   logic               inside_res;
   logic               cloud_done;
   logic               centroid_valid;
   logic signed [15:0] centroid_x;
   logic signed [15:0] centroid_y;
   logic signed [15:0] centroid_z;
   logic [20:0]        inside_count;
   modport source(output valid, inside_res, cloud_done, centroid_valid, centroid_x,
                  centroid_y, centroid_z, inside_count, input ready);
   modport sink(input valid, inside_res, cloud_done, centroid_valid, centroid_x,
                centroid_y, centroid_z, inside_count, output ready);
endinterface

interface fcc_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [63:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/core/frustum_crop_centroid_top.sv -----
// path: stage-one product registers, then the queue, then the result register; a closing
//    point with inside points also passes through the three parallel dividers
// throughput: one point per cycle while the queue has room; each closing point with a
//    centroid holds the back end while it divides, and a 4-word queue keeps the front running
// reset: synchronous, clears plane registers, sums, count, queue and result valid
module frustum_crop_centroid_top #(
   parameter int MAX_POINTS = 1048576
) (
   input  logic       clock,
   input  logic       reset,
   fcc_req_if.sink    req_bus,
   fcc_rsp_if.source  rsp_bus,
   fcc_csr_if.sink    csr_bus
);

   localparam int CNT_W   = $clog2(MAX_POINTS + 1);
   localparam int SUM_W   = fcc_pkg::COORD_W + CNT_W;
   localparam int ENTRY_W = 2 + 3 * SUM_W + CNT_W;

   logic                         push, pop, not_empty;
   logic [ENTRY_W-1:0]           push_data, head;
   logic [fcc_pkg::QFILL_W-1:0]  fill;

   assign csr_bus.ready = 1'b1;

   fcc_front #(.MAX_POINTS(MAX_POINTS), .CNT_W(CNT_W), .SUM_W(SUM_W), .ENTRY_W(ENTRY_W))
   u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_bus.valid),
      .csr_idx   (csr_bus.index),
      .csr_data  (csr_bus.data),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .px        (req_bus.point_x),
      .py        (req_bus.point_y),
      .pz        (req_bus.point_z),
      .p_invalid (req_bus.point_invalid),
      .p_last    (req_bus.last_point),
      .q_fill    (fill),
      .push      (push),
      .push_data (push_data)
   );

   fcc_queue #(.W(ENTRY_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .fill      (fill)
   );

   fcc_back #(.CNT_W(CNT_W), .SUM_W(SUM_W), .ENTRY_W(ENTRY_W)) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .not_empty (not_empty),
      .pop       (pop),
      .rsp       (rsp_bus)
   );

endmodule

// ----- rtl/core/fcc_front.sv -----
module fcc_front #(
   parameter int MAX_POINTS = 1048576,
   parameter int CNT_W      = 21,
   parameter int SUM_W      = 37,
   parameter int ENTRY_W    = 2 + 3 * SUM_W + CNT_W
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [fcc_pkg::CSR_IDX_W-1:0]       csr_idx,
   input  logic [fcc_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [fcc_pkg::COORD_W-1:0]  px,
   input  logic signed [fcc_pkg::COORD_W-1:0]  py,
   input  logic signed [fcc_pkg::COORD_W-1:0]  pz,
   input  logic                                p_invalid,
   input  logic                                p_last,
   input  logic [fcc_pkg::QFILL_W-1:0]         q_fill,
   output logic                                push,
   output logic [ENTRY_W-1:0]                  push_data
);

   fcc_pkg::plane_type plane_ff [fcc_pkg::NUM_FACES];

   logic                               v1_ff, v1_in;
   logic signed [fcc_pkg::PROD_W-1:0]  px_ff [fcc_pkg::NUM_FACES];
   logic signed [fcc_pkg::PROD_W-1:0]  py_ff [fcc_pkg::NUM_FACES];
   logic signed [fcc_pkg::PROD_W-1:0]  pz_ff [fcc_pkg::NUM_FACES];
   logic signed [fcc_pkg::OFF_W-1:0]   off_ff [fcc_pkg::NUM_FACES];
   logic signed [fcc_pkg::COORD_W-1:0] x1_ff, y1_ff, z1_ff;
   logic                               inv1_ff, last1_ff;

   logic signed [SUM_W-1:0] sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [SUM_W-1:0] sx_upd, sy_upd, sz_upd;
   logic [CNT_W-1:0]        cnt_upd;
   logic [fcc_pkg::NUM_FACES-1:0] below;
   logic                    in_box;
   logic                    take;

   assign in_ready = ({1'b0, q_fill} + {{fcc_pkg::QFILL_W{1'b0}}, v1_ff})
                     < (fcc_pkg::QFILL_W + 1)'(fcc_pkg::QDEPTH);
   assign take = in_valid && in_ready;
   assign v1_in = take;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fcc_pkg::NUM_FACES; i++) plane_ff[i] <= '0;
      end else if (csr_we) begin
         case (csr_idx)
            fcc_pkg::CSR_FACE_ONE:   plane_ff[0] <= csr_data;
            fcc_pkg::CSR_FACE_TWO:   plane_ff[1] <= csr_data;
            fcc_pkg::CSR_FACE_THREE: plane_ff[2] <= csr_data;
            fcc_pkg::CSR_FACE_FOUR:  plane_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // stage one: the twelve normal products
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= v1_in;
      if (take) begin
         for (int i = 0; i < fcc_pkg::NUM_FACES; i++) begin
            px_ff[i]  <= plane_ff[i].nx * px;
            py_ff[i]  <= plane_ff[i].ny * py;
            pz_ff[i]  <= plane_ff[i].nz * pz;
            off_ff[i] <= plane_ff[i].off;
         end
         x1_ff    <= px;
         y1_ff    <= py;
         z1_ff    <= pz;
         inv1_ff  <= p_invalid;
         last1_ff <= p_last;
      end
   end

   // stage two: distances, test, accumulate
   always_comb begin
      for (int i = 0; i < fcc_pkg::NUM_FACES; i++) begin
         below[i] = (fcc_pkg::DIST_W'(px_ff[i]) + fcc_pkg::DIST_W'(py_ff[i])
                   + fcc_pkg::DIST_W'(pz_ff[i]) - fcc_pkg::DIST_W'(off_ff[i])) < 0;
      end
      in_box = !inv1_ff && (&below);
      sx_upd = sx_ff;
      sy_upd = sy_ff;
      sz_upd = sz_ff;
      cnt_upd = cnt_ff;
      if (in_box && (cnt_ff < CNT_W'(MAX_POINTS))) begin
         sx_upd  = sx_ff + SUM_W'(x1_ff);
         sy_upd  = sy_ff + SUM_W'(y1_ff);
         sz_upd  = sz_ff + SUM_W'(z1_ff);
         cnt_upd = cnt_ff + 1'b1;
      end
      sx_in = sx_ff;
      sy_in = sy_ff;
      sz_in = sz_ff;
      cnt_in = cnt_ff;
      if (v1_ff) begin
         if (last1_ff) begin
            sx_in = '0;
            sy_in = '0;
            sz_in = '0;
            cnt_in = '0;
         end else begin
            sx_in = sx_upd;
            sy_in = sy_upd;
            sz_in = sz_upd;
            cnt_in = cnt_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sx_ff  <= '0;
         sy_ff  <= '0;
         sz_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         sx_ff  <= sx_in;
         sy_ff  <= sy_in;
         sz_ff  <= sz_in;
         cnt_ff <= cnt_in;
      end
   end

   assign push      = v1_ff;
   assign push_data = {in_box, last1_ff, sx_upd, sy_upd, sz_upd, cnt_upd};

endmodule

// ----- rtl/core/fcc_queue.sv -----
module fcc_queue #(
   parameter int W = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [W-1:0]                  push_data,
   input  logic                          pop,
   output logic [W-1:0]                  head,
   output logic                          not_empty,
   output logic [fcc_pkg::QFILL_W-1:0]   fill
);

   logic [W-1:0]                  mem_ff [fcc_pkg::QDEPTH];
   logic [fcc_pkg::QPTR_W-1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [fcc_pkg::QFILL_W-1:0]   fill_ff, fill_in;

   always_comb begin
      wp_in = push ? wp_ff + 1'b1 : wp_ff;
      rp_in = pop ? rp_ff + 1'b1 : rp_ff;
      fill_in = fill_ff + {{(fcc_pkg::QFILL_W-1){1'b0}}, push}
                - {{(fcc_pkg::QFILL_W-1){1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         fill_ff <= fill_in;
      end
      if (push) mem_ff[wp_ff] <= push_data;
   end

   assign head      = mem_ff[rp_ff];
   assign not_empty = fill_ff != '0;
   assign fill      = fill_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && fill_ff == fcc_pkg::QFILL_W'(fcc_pkg::QDEPTH)))
      else $error("word pushed into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> fill_ff != '0)
      else $error("word popped from empty queue");

endmodule

// ----- rtl/core/fcc_back.sv -----
module fcc_back #(
   parameter int CNT_W   = 21,
   parameter int SUM_W   = 37,
   parameter int ENTRY_W = 2 + 3 * SUM_W + CNT_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [ENTRY_W-1:0] head,
   input  logic               not_empty,
   output logic               pop,
   fcc_rsp_if.source          rsp
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DIV  = 1'b1;
   localparam int   STEP_W  = $clog2(SUM_W);

   fcc_pkg::flags_type      hflags;
   logic signed [SUM_W-1:0] hsum [3];
   logic [CNT_W-1:0]        hcnt;

   logic                    state_ff, state_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [SUM_W-1:0]        q_ff [3];
   logic [SUM_W-1:0]        q_in [3];
   logic [CNT_W-1:0]        r_ff [3];
   logic [CNT_W-1:0]        r_in [3];
   logic                    neg_ff [3];
   logic [CNT_W-1:0]        d_ff;
   fcc_pkg::flags_type      fl_ff;

   logic                    rv_ff, rv_in;
   logic                    o_inside_ff, o_done_ff, o_cv_ff;
   logic signed [15:0]      o_c_ff [3];
   logic [fcc_pkg::OUT_CNT_W-1:0] o_cnt_ff;

   logic                    free, direct, div_done;
   logic [CNT_W:0]          shifted [3];
   logic [SUM_W-1:0]        qneg [3];

   assign {hflags, hsum[0], hsum[1], hsum[2], hcnt} = head;

   assign free     = !rv_ff || rsp.ready;
   assign pop      = (state_ff == ST_IDLE) && not_empty && free;
   assign direct   = pop && !(hflags.last && hcnt != '0);
   assign div_done = (state_ff == ST_DIV) && (step_ff == STEP_W'(SUM_W - 1));

   // one restoring step per cycle on all three axes
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         shifted[k] = {r_ff[k], q_ff[k][SUM_W-1]};
         if (shifted[k] >= {1'b0, d_ff}) begin
            r_in[k] = CNT_W'(shifted[k] - {1'b0, d_ff});
            q_in[k] = {q_ff[k][SUM_W-2:0], 1'b1};
         end else begin
            r_in[k] = shifted[k][CNT_W-1:0];
            q_in[k] = {q_ff[k][SUM_W-2:0], 1'b0};
         end
         qneg[k] = neg_ff[k] ? -q_in[k] : q_in[k];
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop && !direct) begin
               state_in = ST_DIV;
               step_in  = '0;
            end
         end
         ST_DIV: begin
            if (div_done) state_in = ST_IDLE;
            else step_in = step_ff + 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase
      rv_in = rv_ff;
      if (direct || div_done) rv_in = 1'b1;
      else if (rsp.ready) rv_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         rv_ff    <= rv_in;
      end
      if (pop && !direct) begin
         for (int k = 0; k < 3; k++) begin
            neg_ff[k] <= hsum[k][SUM_W-1];
            q_ff[k]   <= hsum[k][SUM_W-1] ? -hsum[k] : hsum[k];
            r_ff[k]   <= '0;
         end
         d_ff  <= hcnt;
         fl_ff <= hflags;
      end else if (state_ff == ST_DIV) begin
         for (int k = 0; k < 3; k++) begin
            q_ff[k] <= q_in[k];
            r_ff[k] <= r_in[k];
         end
      end
      if (direct) begin
         o_inside_ff <= hflags.hit;
         o_done_ff   <= hflags.last;
         o_cv_ff     <= 1'b0;
         for (int k = 0; k < 3; k++) o_c_ff[k] <= '0;
         o_cnt_ff    <= hflags.last ? fcc_pkg::OUT_CNT_W'(hcnt) : '0;
      end else if (div_done) begin
         o_inside_ff <= fl_ff.hit;
         o_done_ff   <= fl_ff.last;
         o_cv_ff     <= 1'b1;
         for (int k = 0; k < 3; k++) o_c_ff[k] <= qneg[k][15:0];
         o_cnt_ff    <= fcc_pkg::OUT_CNT_W'(d_ff);
      end
   end

   assign rsp.valid          = rv_ff;
   assign rsp.inside_res     = o_inside_ff;
   assign rsp.cloud_done     = o_done_ff;
   assign rsp.centroid_valid = o_cv_ff;
   assign rsp.centroid_x     = o_c_ff[0];
   assign rsp.centroid_y     = o_c_ff[1];
   assign rsp.centroid_z     = o_c_ff[2];
   assign rsp.inside_count   = o_cnt_ff;

   a_div_slot_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> !rv_ff)
      else $error("result register busy during division");
   a_cv_needs_done: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && o_cv_ff) |-> (o_done_ff && o_cnt_ff != '0 || CNT_W > fcc_pkg::OUT_CNT_W))
      else $error("centroid valid without closing word");

endmodule

// ----- tb/sv/tb_frustum_crop_centroid_top.sv -----
module tb_frustum_crop_centroid_top;
   import fcc_pkg::*;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic               invalid;
      logic               last;
   } point_word;

   typedef struct packed {
      logic               hit;
      logic               done;
      logic               cvalid;
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic signed [15:0] cz;
      logic [20:0]        count;
   } centroid_word;

   // directed row: point plus an optional typed-in result
   typedef struct packed {
      point_word    pt;
      logic         has_exp;
      centroid_word exp;
   } stim_row;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #1 clock = ~clock;

   fcc_req_if req_bus();
   fcc_rsp_if rsp_bus();
   fcc_csr_if csr_bus();

   frustum_crop_centroid_top dut (
      .clock(clock), .reset(reset),
      .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source), .csr_bus(csr_bus.sink)
   );

   logic [63:0]       face_planes [NUM_FACES];
   logic signed [36:0] acc_x, acc_y, acc_z;
   logic [20:0]       acc_count;
   centroid_word      centroid_queue[$];
   int                error_count = 0;
   int                word_count = 0;
   int                cloud_count = 0;
   int                idle_cycles = 0;
   int                hold_left = 0;
   bit                hold_seen = 1'b0;
   bit                hold_rsp = 1'b0;
   bit                stim_done = 1'b0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d (word %0d)", what, got, want, word_count);
      error_count++;
   endtask

   function automatic bit below_face(input logic [63:0] p, input point_word pt);
      longint margin;
      margin = longint'($signed(p[11:0])) * pt.x + longint'($signed(p[23:12])) * pt.y
             + longint'($signed(p[35:24])) * pt.z - longint'($signed(p[63:36]));
      return margin < 0;
   endfunction

   function automatic centroid_word crop_point(input point_word pt);
      centroid_word r;
      bit in;
      longint n;
      r = '0;
      in = !pt.invalid;
      for (int i = 0; i < NUM_FACES; i++)
         if (in) in = below_face(face_planes[i], pt);
      if (in && acc_count < 21'(1048576)) begin
         acc_x += pt.x;
         acc_y += pt.y;
         acc_z += pt.z;
         acc_count++;
      end
      r.hit = in;
      r.done = pt.last;
      if (pt.last) begin
         if (acc_count != 0) begin
            n = acc_count;
            r.cvalid = 1'b1;
            r.cx = 16'(longint'(acc_x) / n);
            r.cy = 16'(longint'(acc_y) / n);
            r.cz = 16'(longint'(acc_z) / n);
         end
         r.count = acc_count;
         acc_x = '0; acc_y = '0; acc_z = '0; acc_count = '0;
      end
      return r;
   endfunction

   function automatic logic [63:0] pack_plane(int nx, int ny, int nz, int off);
      return {28'(off), 12'(nz), 12'(ny), 12'(nx)};
   endfunction

   task automatic write_face(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      face_planes[idx[1:0]] = val;
      @(posedge clock);
   endtask

   task automatic drain_block;
      req_bus.valid <= 1'b0;
      while (centroid_queue.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic send_point(input point_word pt, input bit has_exp, input centroid_word exp);
      centroid_word pred;
      req_bus.valid         <= 1'b1;
      req_bus.point_x       <= pt.x;
      req_bus.point_y       <= pt.y;
      req_bus.point_z       <= pt.z;
      req_bus.point_invalid <= pt.invalid;
      req_bus.last_point    <= pt.last;
      do @(posedge clock); while (!req_bus.ready);
      pred = crop_point(pt);
      if (has_exp && pred != exp)
         report_mismatch("typed-in row", 64'(pred), 64'(exp));
      centroid_queue = {centroid_queue, pred};
      if (pt.last) cloud_count++;
   endtask

   task automatic gap_sender;
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return;
      req_bus.valid <= 1'b0;
      if (r < 95) repeat ($urandom_range(1, 3)) @(posedge clock);
      else repeat ($urandom_range(10, 40)) @(posedge clock);
   endtask

   // planes that bound x and y around the origin (the fourth also tilts with z) so clouds have inside points
   task automatic load_box(input int half);
      write_face(CSR_FACE_ONE,   pack_plane(2047, 0, 0, half * 2047));
      write_face(CSR_FACE_TWO,   pack_plane(-2048, 0, 0, half * 2048));
      write_face(CSR_FACE_THREE, pack_plane(0, 2047, 0, half * 2047));
      write_face(CSR_FACE_FOUR,  pack_plane(0, -2048, 1, half * 2048));
   endtask

   function automatic point_word rand_point(input int half, input int last_pct);
      point_word pt;
      if ($urandom_range(0, 3) != 0) begin
         pt.x = 16'($signed($urandom_range(0, 2 * half)) - half);
         pt.y = 16'($signed($urandom_range(0, 2 * half)) - half);
         pt.z = 16'($signed($urandom_range(0, 2 * half)) - half);
      end else begin
         pt.x = 16'($urandom);
         pt.y = 16'($urandom);
         pt.z = 16'($urandom);
      end
      pt.invalid = ($urandom_range(0, 19) == 0);
      pt.last = ($urandom_range(0, 99) < last_pct);
      return pt;
   endfunction

   initial begin
      stim_row rows[$];
      stim_row row;
      point_word pt;
      centroid_word z;
      int half;
      z = '0;
      req_bus.valid = 1'b0;
      req_bus.point_x = '0;
      req_bus.point_y = '0;
      req_bus.point_z = '0;
      req_bus.point_invalid = 1'b0;
      req_bus.last_point = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      for (int i = 0; i < NUM_FACES; i++) face_planes[i] = '0;
      acc_x = '0; acc_y = '0; acc_z = '0; acc_count = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset planes: nothing inside, last gives empty centroid
      row = '0; row.pt = {16'sd32767, -16'sd32768, 16'sd0, 1'b0, 1'b0};
      row.has_exp = 1'b1; row.exp = z; rows = {rows, row};
      row.pt = {-16'sd32768, 16'sd32767, -16'sd1, 1'b0, 1'b1};
      row.exp = z; row.exp.done = 1'b1; rows = {rows, row};
      row.pt = {16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1};
      rows = {rows, row};
      foreach (rows[i]) send_point(rows[i].pt, rows[i].has_exp, rows[i].exp);
      drain_block();

      // wide-open planes: everything valid is inside
      for (int i = 0; i < NUM_FACES; i++)
         write_face(CSR_IDX_W'(i), {28'sh7FFFFFF, 36'h0});
      rows.delete();
      row = '0;
      row.pt = {16'sd32767, 16'sd32767, 16'sd32767, 1'b0, 1'b0}; rows = {rows, row};
      row.pt = {-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 1'b0}; rows = {rows, row};
      row.pt = {16'sd5, 16'sd5, 16'sd5, 1'b1, 1'b0}; rows = {rows, row};
      row.pt = {16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1}; rows = {rows, row};
      row.pt = {-16'sd7, 16'sd7, 16'sd1, 1'b0, 1'b0}; rows = {rows, row};
      row.pt = {-16'sd2, 16'sd0, 16'sd3, 1'b0, 1'b1}; rows = {rows, row};
      row.pt = {16'sd9, 16'sd9, 16'sd9, 1'b1, 1'b1}; rows = {rows, row};
      foreach (rows[i]) send_point(rows[i].pt, rows[i].has_exp, rows[i].exp);
      drain_block();

      // extreme planes: most negative offset and normals
      for (int i = 0; i < NUM_FACES; i++)
         write_face(CSR_IDX_W'(i), {28'sh8000000, 12'h800, 12'h800, 12'h800});
      send_point({16'sd32767, 16'sd32767, 16'sd32767, 1'b0, 1'b0}, 1'b0, z);
      send_point({-16'sd32768, 16'sd1, 16'sd0, 1'b0, 1'b1}, 1'b0, z);
      drain_block();
      for (int i = 0; i < NUM_FACES; i++)
         write_face(CSR_IDX_W'(i), 64'hFFFF_FFFF_FFFF_FFFF);
      send_point({16'sd100, -16'sd100, 16'sd3, 1'b0, 1'b1}, 1'b0, z);
      drain_block();

      // random phases over several box sizes; one phase has a long receiver stall
      for (int phase = 0; phase < 6; phase++) begin
         half = (phase == 0) ? 1 : (phase == 5) ? 30000 : $urandom_range(10, 3000);
         load_box(half);
         for (int n = 0; n < 240; n++) begin
            pt = rand_point(half, (phase == 2) ? 1 : 8);
            if (phase == 3 && n == 120) hold_rsp = 1'b1;
            send_point(pt, 1'b0, z);
            if (phase != 3 && n % 5 != 0) gap_sender();
         end
         send_point(rand_point(half, 100), 1'b0, z);
         // pause until every expected word has arrived
         drain_block();
      end

      stim_done = 1'b1;
   end

   // receiver pressure: random ready throughout, plus one long hold-off during the stall phase
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_rsp && !hold_seen) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= 79;
         hold_seen <= 1'b1;
      end else begin
         case ($urandom_range(0, 19))
            0, 1, 2: rsp_bus.ready <= 1'b0;
            3: rsp_bus.ready <= ($urandom_range(0, 9) == 0);
            default: rsp_bus.ready <= 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin
      centroid_word want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         word_count++;
         if (centroid_queue.size() == 0) begin
            $display("unexpected result word %0d", word_count);
            error_count++;
         end else begin
            want = centroid_queue.pop_front();
            if (rsp_bus.inside_res !== want.hit)
               report_mismatch("inside_res", rsp_bus.inside_res, want.hit);
            if (rsp_bus.cloud_done !== want.done)
               report_mismatch("cloud_done", rsp_bus.cloud_done, want.done);
            if (rsp_bus.centroid_valid !== want.cvalid)
               report_mismatch("centroid_valid", rsp_bus.centroid_valid, want.cvalid);
            if (rsp_bus.centroid_x !== want.cx)
               report_mismatch("centroid_x", rsp_bus.centroid_x, want.cx);
            if (rsp_bus.centroid_y !== want.cy)
               report_mismatch("centroid_y", rsp_bus.centroid_y, want.cy);
            if (rsp_bus.centroid_z !== want.cz)
               report_mismatch("centroid_z", rsp_bus.centroid_z, want.cz);
            if (rsp_bus.inside_count !== want.count)
               report_mismatch("inside_count", rsp_bus.inside_count, want.count);
         end
      end
   end

   // watchdog on cycles with no accepted word on any channel
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      while (centroid_queue.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("checked %0d result words over %0d clouds, all four faces reprogrammed",
               word_count, cloud_count);
      if (error_count == 0 && centroid_queue.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/fcc_pkg.sv
rtl/core/fcc_if.sv
rtl/core/fcc_front.sv
rtl/core/fcc_queue.sv
rtl/core/fcc_back.sv
rtl/core/frustum_crop_centroid_top.sv
tb/sv/tb_frustum_crop_centroid_top.sv
